[hw/rtl/ertm_pkg.sv]
// Shared constants and the divider cell record for the tone mapper.
package ertm_pkg;

	localparam int CW = 24;          // channel code width, Q8.16
	localparam int NW = 66;          // numerator / remainder width
	localparam int QW = 8;           // quotient bits, one per cell
	localparam int NCH = 3;          // red, green, blue

	localparam logic [15:0] LUMA_WR = 16'd13933;
	localparam logic [15:0] LUMA_WG = 16'd46871;
	localparam logic [15:0] LUMA_WB = 16'd4732;
	localparam logic [15:0] WP_RESET = 16'd256;

	typedef struct packed {
		logic                      valid;
		logic                      last;
		logic [NW-1:0]             dv;
		logic [NCH-1:0]            sat;
		logic [NCH-1:0][NW-1:0]    rem;
		logic [NCH-1:0][QW-1:0]    quo;
	} cell_t;

endpackage

[hw/rtl/ertm_cell.sv]
// One restoring-division step for all three channels, divisor halves per cell.
module ertm_cell
	import ertm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t d,
	output cell_t q
);

	cell_t nxt;
	cell_t data_q;
	logic  valid_q;

	always_comb begin
		nxt = d;
		nxt.dv = d.dv >> 1;
		for (int i = 0; i < NCH; i++) begin
			if (d.rem[i] >= d.dv) begin
				nxt.rem[i] = d.rem[i] - d.dv;
				nxt.quo[i] = {d.quo[i][QW-2:0], 1'b1};
			end else begin
				nxt.quo[i] = {d.quo[i][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end

endmodule

[hw/rtl/extended_reinhard_tone_map.sv]
// Top level: extended Reinhard tone mapping, one RGB pixel per clock.
//
// Input: a pixel is taken at each clock edge with start high; busy is tied
// low, so a new pixel may follow every cycle.
// Config: white_point (Q8.8) is written on cfg_data when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Output: each result appears for one cycle with strobe high, in input order.
// The receiver cannot stall.
// Throughput: one pixel per cycle. The pipeline is four arithmetic stages
// (luma products, luma sum, numerator/denominator products, overflow check),
// a row of eight divider cells, one quotient bit each, and the output register.
// Reset clears the pipeline valid flags and loads white point 1.0.
module extended_reinhard_tone_map
	import ertm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [CW-1:0] red_in,
	input  logic [CW-1:0] green_in,
	input  logic [CW-1:0] blue_in,
	input  logic          last_in,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data,
	output logic          strobe,
	output logic [7:0]    red_out,
	output logic [7:0]    green_out,
	output logic [7:0]    blue_out,
	output logic          last_out
);

	logic [31:0] w2_q;
	logic [15:0] wp_eff;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign wp_eff    = (cfg_data == 16'd0) ? 16'd1 : cfg_data;

	// w^2 is latched with the register itself, so no stage lags a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w2_q <= 32'(WP_RESET) * 32'(WP_RESET);
		end else if (cfg_valid && cfg_ready) begin
			w2_q <= 32'(wp_eff) * 32'(wp_eff);
		end
	end

	// stage 1: luma products and C*255
	logic                       v_s1, last_s1;
	logic [39:0]                pr_s1, pg_s1, pb_s1;
	logic [NCH-1:0][31:0]       a_s1;
	logic [NCH-1:0][CW-1:0]     ch;

	assign ch[0] = red_in;
	assign ch[1] = green_in;
	assign ch[2] = blue_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= last_in;
		pr_s1   <= 40'(red_in) * 40'(LUMA_WR);
		pg_s1   <= 40'(green_in) * 40'(LUMA_WG);
		pb_s1   <= 40'(blue_in) * 40'(LUMA_WB);
		for (int i = 0; i < NCH; i++) begin
			a_s1[i] <= (32'(ch[i]) << 8) - 32'(ch[i]);
		end
	end

	// stage 2: luminance sum
	logic                 v_s2, last_s2;
	logic [CW-1:0]        lq_s2;
	logic [NCH-1:0][31:0] a_s2;
	logic [39:0]          lsum;

	assign lsum = pr_s1 + pg_s1 + pb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		lq_s2   <= lsum[39:16];
		a_s2    <= a_s1;
	end

	// stage 3: numerators and denominator
	logic                   v_s3, last_s3;
	logic [NCH-1:0][NW-1:0] n_s3;
	logic [NW-1:0]          d_s3;
	logic [32:0]            wl;

	assign wl = 33'(w2_q) + 33'(lq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s3 <= last_s2;
		d_s3    <= NW'(w2_q) * NW'(25'(lq_s2) + 25'h10000);
		for (int i = 0; i < NCH; i++) begin
			n_s3[i] <= NW'(a_s2[i]) * NW'(wl);
		end
	end

	// stage 4: saturation check, seed of the divider row
	cell_t         seed;
	cell_t         head_s4;
	cell_t         head;
	logic          v_s4;
	logic [NW-1:0] d256;

	assign d256 = d_s3 << 8;

	always_comb begin
		seed.valid = v_s3;
		seed.last  = last_s3;
		seed.dv    = d_s3 << 7;
		seed.rem   = n_s3;
		seed.quo   = '0;
		for (int i = 0; i < NCH; i++) begin
			seed.sat[i] = (n_s3[i] >= d256);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		head_s4 <= seed;
	end

	always_comb begin
		head = head_s4;
		head.valid = v_s4;
	end

	cell_t link [QW+1];

	assign link[0] = head;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		ertm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (link[k]),
			.q      (link[k+1])
		);
	end

	// output register
	cell_t tail;
	assign tail = link[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_out  <= tail.last;
		red_out   <= tail.sat[0] ? 8'hFF : tail.quo[0];
		green_out <= tail.sat[1] ? 8'hFF : tail.quo[1];
		blue_out  <= tail.sat[2] ? 8'hFF : tail.quo[2];
	end

endmodule
